### rtl/core/gfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gfv_pkg;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int G_W     = 32;
  localparam int FORCE_W = 48;
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 64;
  localparam int R2_W    = 66;
  localparam int X_W     = 98;
  localparam int ROOT_W  = 49;
  localparam int DEN_W   = 115;
  localparam int BASE_W  = 94;
  localparam int PROD_W  = 126;
  localparam int QUO_W   = 48;
  localparam int SQRT_SHIFT = 32;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_M1_BAD    = 2'd1;
  localparam logic [1:0] STATUS_M2_BAD    = 2'd2;
  localparam logic [1:0] STATUS_COINCIDE  = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0]  first_pos_x;
    logic signed [POS_W-1:0]  first_pos_y;
    logic signed [POS_W-1:0]  first_pos_z;
    logic signed [POS_W-1:0]  second_pos_x;
    logic signed [POS_W-1:0]  second_pos_y;
    logic signed [POS_W-1:0]  second_pos_z;
    logic signed [MASS_W-1:0] first_mass;
    logic signed [MASS_W-1:0] second_mass;
  } gfv_req_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic [1:0]                status;
    logic                      saturated;
  } gfv_rsp_t;

endpackage
`default_nettype wire

### rtl/core/gfv_delay.sv
`timescale 1ns / 1ps
`default_nettype none
module gfv_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < N; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[N-1];

endmodule
`default_nettype wire

### rtl/core/gfv_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module gfv_mul #(
  parameter int A_W  = 32,
  parameter int B_W  = 32,
  parameter int A_CH = 32,
  parameter int B_CH = 32
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int NA   = (A_W + A_CH - 1) / A_CH;
  localparam int NB   = (B_W + B_CH - 1) / B_CH;
  localparam int LAT  = NA * NB;
  localparam int AP_W = NA * A_CH;
  localparam int BP_W = NB * B_CH;
  localparam int P_W  = A_W + B_W;

  logic [AP_W-1:0] a_pipe   [LAT+1];
  logic [BP_W-1:0] b_pipe   [LAT+1];
  logic [P_W-1:0]  acc_pipe [LAT+1];

  assign a_pipe[0]   = AP_W'(a);
  assign b_pipe[0]   = BP_W'(b);
  assign acc_pipe[0] = '0;

  // One partial product per stage, accumulated at its weight.
  for (genvar s = 0; s < LAT; s++) begin : g_stage
    localparam int IA = s / NB;
    localparam int IB = s % NB;
    localparam int SH = IA * A_CH + IB * B_CH;
    logic [A_CH+B_CH-1:0] part;

    assign part = a_pipe[s][IA*A_CH +: A_CH] * b_pipe[s][IB*B_CH +: B_CH];

    always_ff @(posedge clk) begin
      a_pipe[s+1]   <= a_pipe[s];
      b_pipe[s+1]   <= b_pipe[s];
      acc_pipe[s+1] <= acc_pipe[s] + (P_W'(part) << SH);
    end
  end

  assign p = acc_pipe[LAT];

endmodule
`default_nettype wire

### rtl/core/gfv_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module gfv_isqrt (
  input  logic                    clk,
  input  logic [gfv_pkg::X_W-1:0] x,
  output logic [gfv_pkg::ROOT_W-1:0] root,
  output logic [gfv_pkg::X_W-1:0] x_out
);
  import gfv_pkg::*;

  localparam int XE_W = X_W + 1;

  logic [X_W-1:0]    x_pipe    [ROOT_W+1];
  logic [ROOT_W-1:0] root_pipe [ROOT_W+1];
  logic [X_W-1:0]    sq_pipe   [ROOT_W+1];

  assign x_pipe[0]    = x;
  assign root_pipe[0] = '0;
  assign sq_pipe[0]   = '0;

  // Each stage tries one root bit, from the top down. The running square
  // is updated incrementally: (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b).
  for (genvar s = 0; s < ROOT_W; s++) begin : g_bit
    localparam int B = ROOT_W - 1 - s;
    logic [XE_W-1:0] cand;

    assign cand = XE_W'(sq_pipe[s]) + (XE_W'(root_pipe[s]) << (B + 1))
                  + (XE_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      x_pipe[s+1] <= x_pipe[s];
      if (cand <= XE_W'(x_pipe[s])) begin
        root_pipe[s+1] <= root_pipe[s] | (ROOT_W'(1) << B);
        sq_pipe[s+1]   <= cand[X_W-1:0];
      end else begin
        root_pipe[s+1] <= root_pipe[s];
        sq_pipe[s+1]   <= sq_pipe[s];
      end
    end
  end

  assign root  = root_pipe[ROOT_W];
  assign x_out = x_pipe[ROOT_W];

endmodule
`default_nettype wire

### rtl/core/gfv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module gfv_div #(
  parameter int NUM_W = 163
) (
  input  logic                      clk,
  input  logic [NUM_W-1:0]          num,
  input  logic [gfv_pkg::DEN_W-1:0] den,
  output logic [gfv_pkg::QUO_W-1:0] quo,
  output logic                      over
);
  import gfv_pkg::*;

  logic [NUM_W-1:0] rem_pipe  [QUO_W+1];
  logic [DEN_W-1:0] den_pipe  [QUO_W+1];
  logic [QUO_W-1:0] quo_pipe  [QUO_W+1];
  logic             over_pipe [QUO_W+1];

  // A quotient that does not fit in QUO_W bits is flagged up front, so
  // only the low QUO_W quotient bits need restoring steps.
  always_ff @(posedge clk) begin
    rem_pipe[0]  <= num;
    den_pipe[0]  <= den;
    quo_pipe[0]  <= '0;
    over_pipe[0] <= num >= (NUM_W'(den) << QUO_W);
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_bit
    localparam int K = QUO_W - 1 - s;
    logic [NUM_W-1:0] shifted;

    assign shifted = NUM_W'(den_pipe[s]) << K;

    always_ff @(posedge clk) begin
      den_pipe[s+1]  <= den_pipe[s];
      over_pipe[s+1] <= over_pipe[s];
      if (rem_pipe[s] >= shifted) begin
        rem_pipe[s+1] <= rem_pipe[s] - shifted;
        quo_pipe[s+1] <= quo_pipe[s] | (QUO_W'(1) << K);
      end else begin
        rem_pipe[s+1] <= rem_pipe[s];
        quo_pipe[s+1] <= quo_pipe[s];
      end
    end
  end

  assign quo  = quo_pipe[QUO_W];
  assign over = over_pipe[QUO_W];

endmodule
`default_nettype wire

### rtl/core/gravitational_force_vector.sv
`timescale 1ns / 1ps
`default_nettype none
// Pairwise Newtonian gravity: force on the first body toward the second.
// A request is taken on item when start is high and busy is low; busy is
// high only while rst is asserted, so one request may enter every cycle.
// Each request gives exactly one response on result, marked by a one-cycle
// result_valid strobe from the end of the vld shift register. Throughput is
// one request per cycle: the square root, the multipliers and the three
// dividers are fully pipelined, one root bit and one quotient bit per
// stage, so the 49-bit root and the 48-bit quotients set the latency.
// The receiver cannot stall; responses appear in request order.
// G is written through cfg_we/cfg_data (unsigned Q16.16) and must only be
// changed while no request is in flight. Reset sets G to 1.0 and drops
// every request in flight; no response is produced for them.
// force_x/y/z are signed with FRACTION_BITS fraction bits. A non-positive
// mass or coincident positions give zero force and a nonzero status;
// components out of range are clamped and flagged in saturated.
module gravitational_force_vector #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              start,
  output logic              busy,
  input  gfv_pkg::gfv_req_t item,
  output logic              result_valid,
  output gfv_pkg::gfv_rsp_t result
);
  import gfv_pkg::*;

  localparam int SHIFT_W = PROD_W + FRACTION_BITS;
  localparam int NUM_W   = (SHIFT_W > DEN_W + QUO_W) ? SHIFT_W : DEN_W + QUO_W;
  localparam int LAT_SQRT = ROOT_W;
  localparam int LAT_MUL  = 6;
  localparam int LAT_DIV  = QUO_W + 1;
  localparam int LAT_TOTAL = 3 + LAT_SQRT + LAT_MUL + LAT_DIV + 1;

  typedef struct packed {
    logic [G_W-1:0]              g;
    logic [MASS_W-2:0]           m1;
    logic [MASS_W-2:0]           m2;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0]                  neg;
    logic [1:0]                  status;
  } side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic [1:0] status;
  } tail_t;

  logic [G_W-1:0]       gravity_constant;
  logic [LAT_TOTAL-1:0] vld;
  logic                 accept;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_constant <= G_W'(65536);
      vld              <= '0;
    end else begin
      if (cfg_we) begin
        gravity_constant <= cfg_data;
      end
      vld <= {vld[LAT_TOTAL-2:0], accept};
    end
  end

  // Front end: differences, magnitudes and mass checks.
  logic signed [POS_W-1:0] first_pos  [3];
  logic signed [POS_W-1:0] second_pos [3];
  side_t                   s1_next;

  assign first_pos[0]  = item.first_pos_x;
  assign first_pos[1]  = item.first_pos_y;
  assign first_pos[2]  = item.first_pos_z;
  assign second_pos[0] = item.second_pos_x;
  assign second_pos[1] = item.second_pos_y;
  assign second_pos[2] = item.second_pos_z;

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    s1_next = '0;
    s1_next.g  = gravity_constant;
    s1_next.m1 = item.first_mass[MASS_W-2:0];
    s1_next.m2 = item.second_mass[MASS_W-2:0];
    for (int i = 0; i < 3; i++) begin
      d = DIFF_W'(second_pos[i]) - DIFF_W'(first_pos[i]);
      m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      s1_next.mag[i] = m[MAG_W-1:0];
      s1_next.neg[i] = d[DIFF_W-1];
    end
    if (item.first_mass[MASS_W-1] || item.first_mass == '0) begin
      s1_next.status = STATUS_M1_BAD;
    end else if (item.second_mass[MASS_W-1] || item.second_mass == '0) begin
      s1_next.status = STATUS_M2_BAD;
    end else begin
      s1_next.status = STATUS_OK;
    end
  end

  side_t              s1_side, s2_side, s3_side, s3_next;
  logic [SQ_W-1:0]    s2_sq [3];
  logic [R2_W-1:0]    s3_r2;
  logic [R2_W-1:0]    r2_sum;

  assign r2_sum = R2_W'(s2_sq[0]) + R2_W'(s2_sq[1]) + R2_W'(s2_sq[2]);

  always_comb begin
    s3_next = s2_side;
    if (s2_side.status == STATUS_OK && r2_sum == '0) begin
      s3_next.status = STATUS_COINCIDE;
    end
  end

  always_ff @(posedge clk) begin
    s1_side <= s1_next;
    s2_side <= s1_side;
    for (int i = 0; i < 3; i++) begin
      s2_sq[i] <= s1_side.mag[i] * s1_side.mag[i];
    end
    s3_r2   <= r2_sum;
    s3_side <= s3_next;
  end

  // Square root of r2 in Q.16; r2 rides along inside the root unit.
  logic [ROOT_W-1:0] rq;
  logic [X_W-1:0]    x_out;
  logic [R2_W-1:0]   r2_d;
  side_t             side_d;

  gfv_isqrt u_isqrt (
    .clk   (clk),
    .x     ({s3_r2, SQRT_SHIFT'(0)}),
    .root  (rq),
    .x_out (x_out)
  );

  gfv_delay #(.W($bits(side_t)), .N(LAT_SQRT)) u_side_dly (
    .clk  (clk),
    .din  (s3_side),
    .dout (side_d)
  );

  assign r2_d = x_out[X_W-1:SQRT_SHIFT];

  // Denominator r2 * rq and numerator G * m1 * m2 * |d|, both 6 stages.
  logic [DEN_W-1:0]      den;
  logic [G_W+MASS_W-2:0] p_gm1;
  logic [BASE_W-1:0]     base;
  logic [2:0][MAG_W-1:0] mag_d;
  tail_t                 tail_in, tail_d;

  gfv_mul #(.A_W(R2_W), .B_W(ROOT_W), .A_CH(22), .B_CH(25)) u_mul_den (
    .clk (clk),
    .a   (r2_d),
    .b   (rq),
    .p   (den)
  );

  gfv_mul #(.A_W(G_W), .B_W(MASS_W-1), .A_CH(32), .B_CH(31)) u_mul_gm1 (
    .clk (clk),
    .a   (side_d.g),
    .b   (side_d.m1),
    .p   (p_gm1)
  );

  logic [MASS_W-2:0] m2_d;

  gfv_delay #(.W(MASS_W-1), .N(1)) u_m2_dly (
    .clk  (clk),
    .din  (side_d.m2),
    .dout (m2_d)
  );

  gfv_mul #(.A_W(G_W+MASS_W-1), .B_W(MASS_W-1), .A_CH(32), .B_CH(31)) u_mul_m2 (
    .clk (clk),
    .a   (p_gm1),
    .b   (m2_d),
    .p   (base)
  );

  gfv_delay #(.W(3*MAG_W), .N(3)) u_mag_dly (
    .clk  (clk),
    .din  (side_d.mag),
    .dout (mag_d)
  );

  assign tail_in.neg    = side_d.neg;
  assign tail_in.status = side_d.status;

  gfv_delay #(.W($bits(tail_t)), .N(LAT_MUL + LAT_DIV)) u_tail_dly (
    .clk  (clk),
    .din  (tail_in),
    .dout (tail_d)
  );

  logic [QUO_W-1:0] quo  [3];
  logic             over [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;

    gfv_mul #(.A_W(BASE_W), .B_W(MAG_W), .A_CH(32), .B_CH(32)) u_mul_mag (
      .clk (clk),
      .a   (base),
      .b   (mag_d[i]),
      .p   (prod)
    );

    assign num = NUM_W'(prod) << FRACTION_BITS;

    gfv_div #(.NUM_W(NUM_W)) u_div (
      .clk  (clk),
      .num  (num),
      .den  (den),
      .quo  (quo[i]),
      .over (over[i])
    );
  end

  // Clamp, apply sign and drop the force when the request was invalid.
  gfv_rsp_t             rsp_next;
  logic [FORCE_W-1:0]   force_v [3];

  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] v;
    logic             sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim = tail_d.neg[i] ? (QUO_W'(1) << (QUO_W - 1))
                          : ((QUO_W'(1) << (QUO_W - 1)) - QUO_W'(1));
      if (over[i] || quo[i] > lim) begin
        v   = lim;
        sat = 1'b1;
      end else begin
        v = quo[i];
      end
      force_v[i] = tail_d.neg[i] ? FORCE_W'(-v) : FORCE_W'(v);
    end
    rsp_next = '0;
    rsp_next.status = tail_d.status;
    if (tail_d.status == STATUS_OK) begin
      rsp_next.force_x   = force_v[0];
      rsp_next.force_y   = force_v[1];
      rsp_next.force_z   = force_v[2];
      rsp_next.saturated = sat;
    end
  end

  always_ff @(posedge clk) begin
    result <= rsp_next;
  end

  assign result_valid = vld[LAT_TOTAL-1];

endmodule
`default_nettype wire
